// File: rtl/transposition_table_bucket_top_assert.svh
// Assertion macros shared by the checker.
`ifndef TRANSPOSITION_TABLE_BUCKET_TOP_ASSERT_SVH
`define TRANSPOSITION_TABLE_BUCKET_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define TTB_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define TTB_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/ttb_pkg.sv
package ttb_pkg;

  localparam int SIDE_ENTRIES = 1024;
  localparam int PROBES       = 4;
  localparam int SLOT_W       = $clog2(SIDE_ENTRIES);
  localparam int ADDR_W       = SLOT_W + 1;
  localparam int DEPTH        = 2 * SIDE_ENTRIES;
  localparam int PRB_W        = (PROBES > 1) ? $clog2(PROBES) : 1;
  localparam int ENTRY_W      = 128;
  localparam int IN_W         = 168;
  localparam int OUT_W        = 96;

  localparam logic [1:0] CFG_INDEX_MASK = 2'd0;
  localparam logic [1:0] CFG_AGE        = 2'd1;
  localparam logic [1:0] CFG_WIN_THR    = 2'd2;
  localparam logic [1:0] CFG_WIN_STEP   = 2'd3;

  localparam logic [3:0] ST_UNKNOWN  = 4'd0;
  localparam logic [3:0] ST_INVALID  = 4'd1;
  localparam logic [3:0] ST_EXACT    = 4'd2;
  localparam logic [3:0] ST_LOWER    = 4'd3;
  localparam logic [3:0] ST_UPPER    = 4'd4;
  localparam logic [3:0] ST_AVOIDNUL = 4'd5;
  localparam logic [3:0] ST_GOOD     = 4'd6;
  localparam logic [3:0] ST_HIT      = 4'd7;
  localparam logic [3:0] ST_RECORDED = 4'd8;

  localparam logic [2:0] BND_EXACT   = 3'd0;
  localparam logic [2:0] BND_LOWER   = 3'd1;
  localparam logic [2:0] BND_UPPER   = 3'd2;
  localparam logic [2:0] BND_INVALID = 3'd3;
  localparam logic [2:0] BND_REFRESH = 3'd4;

endpackage

// File: rtl/ttb_ram.sv
module ttb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/transposition_table_bucket_top.sv
// Two-sided four-way transposition table. Each command (probe or record) reads
// the slots key^0..key^3 of one half through a single RAM port, one slot per
// cycle, with one shared compare/score unit judging each slot as its data returns.
// The scan stops at the first matching slot (or free slot on a record), so it
// judges 1 to 4 slots. Per command: a read-issue step, a judging step per
// slot, a decision step, an optional write step (record store or exclusive
// invalidation) and a step that loads the output register. The next input
// transfer is taken only after the previous command's result has been loaded.
// While an earlier result still waits in the output register the sequencer
// holds before the load, and in_tready stays low. After reset a clearing pass
// writes zero to all 2048 slots, one per cycle, before the first command is
// taken; configuration writes are taken meanwhile.
module transposition_table_bucket_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [14:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,  // cmd (0 probe, 1 record)
  // side, position key, depth, ply, bound, marks, score_or_alpha,
  // eval_or_beta, move, exclusive, zero pad
  input  logic [ttb_pkg::IN_W-1:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, out_score, out_eval, out_move, mate flag, out_singular,
  // stored_depth, zero pad
  output logic [ttb_pkg::OUT_W-1:0] out_tdata
);
  import ttb_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // config
  logic [9:0]  index_mask_r;
  logic [3:0]  age_r;
  logic [14:0] win_thr_r;
  logic [7:0]  win_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_mask_r <= 10'd255;
      age_r        <= 4'd0;
      win_thr_r    <= 15'd3000;
      win_step_r   <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INDEX_MASK: index_mask_r <= cfg_data[9:0];
        CFG_AGE:        age_r        <= cfg_data[3:0];
        CFG_WIN_THR:    win_thr_r    <= cfg_data[14:0];
        CFG_WIN_STEP:   win_step_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // latched request
  logic        cmd_r, side_r, excl_r;
  logic [9:0]  key_r;
  logic [31:0] keyhi_r;
  logic [7:0]  depth_r, ply_r;
  logic [2:0]  bound_r;
  logic        mate_r, sing_r;
  logic signed [15:0] score_r;
  logic [31:0] eval_r, move_r;

  // sequencer counters
  logic [PRB_W:0]  rd_cnt_r, rd_cnt_nxt; // reads issued
  logic [PRB_W:0]  ev_cnt_r, ev_cnt_nxt; // slots judged
  logic [ADDR_W:0] clr_r;

  // scan results
  logic             found_r, hit_r, done_r;
  logic [ADDR_W-1:0] tgt_r;
  logic [9:0]       best_r;
  logic [127:0]     hit_ent_r;

  // output register
  logic [3:0]  o_status_r;
  logic [15:0] o_score_r;
  logic [31:0] o_eval_r, o_move_r;
  logic        o_mate_r, o_sing_r;
  logic [7:0]  o_depth_r;
  logic        out_valid_r;

  // RAM
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [127:0]       ram_wdata, ram_rdata;

  ttb_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  function automatic logic [ADDR_W-1:0] slot_addr(input logic sd, input logic [9:0] k,
                                                  input logic [PRB_W:0] i);
    logic [9:0] x;
    x = k ^ 10'(i);
    return {sd, x[SLOT_W-1:0]};
  endfunction

  assign ram_raddr = slot_addr(side_r, key_r, rd_cnt_r);
  assign in_tready = (state_r == S_IDLE);

  // slot decode
  logic [31:0] e_move, e_eval, e_data, e_chk;
  logic [7:0]  e_flags, e_depth;
  logic [1:0]  e_code;
  logic        e_match, e_empty;
  assign e_move  = ram_rdata[31:0];
  assign e_eval  = ram_rdata[63:32];
  assign e_data  = ram_rdata[95:64];
  assign e_chk   = ram_rdata[127:96];
  assign e_flags = e_data[31:24];
  assign e_depth = e_data[23:16];
  assign e_code  = e_flags[1:0];
  assign e_empty = (e_chk == 32'd0);
  assign e_match = ((e_chk ^ e_move ^ e_eval ^ e_data) == keyhi_r);

  logic [9:0] e_sc;
  assign e_sc = {2'b00, e_flags[7:4], 4'b0000} + {2'b00, e_depth}
              + ((e_code == 2'd0) ? 10'd64 : 10'd0);

  logic rec_stop;
  assign rec_stop = cmd_r && (e_empty || e_match);

  // mate-distance adjust (shared)
  logic [16:0] adj;
  assign adj = 17'(win_step_r) * (17'(ply_r) + 17'd1);

  logic [31:0] h_data, h_move, h_eval;
  assign h_move  = hit_ent_r[31:0];
  assign h_eval  = hit_ent_r[63:32];
  assign h_data  = hit_ent_r[95:64];

  logic signed [15:0] adj_in;
  logic               adj_away;
  logic signed [15:0] adj_out;
  logic signed [18:0] adj_sum;
  assign adj_in   = cmd_r ? score_r : $signed(h_data[15:0]);
  assign adj_away = cmd_r;
  always_comb begin
    adj_sum = 19'(adj_in);
    if (adj_in > $signed({1'b0, win_thr_r})) begin
      adj_sum = adj_away ? 19'(adj_in) + 19'(adj) : 19'(adj_in) - 19'(adj);
    end else if (adj_in < -$signed({1'b0, win_thr_r})) begin
      adj_sum = adj_away ? 19'(adj_in) - 19'(adj) : 19'(adj_in) + 19'(adj);
    end
    if (adj_sum > 19'sd32767)       adj_out = 16'sh7fff;
    else if (adj_sum < -19'sd32768) adj_out = 16'sh8000;
    else                            adj_out = adj_sum[15:0];
  end

  // probe verdict on captured hit
  logic [7:0] h_flags, h_depth;
  logic [1:0] h_code;
  logic [3:0] p_status;
  logic signed [32:0] s33, a33, b33;
  logic        deep, near;
  assign h_flags = h_data[31:24];
  assign h_depth = h_data[23:16];
  assign h_code  = h_flags[1:0];
  assign s33 = 33'(adj_out);
  assign a33 = 33'(score_r);
  assign b33 = 33'($signed(eval_r));
  assign deep = (h_depth >= depth_r);
  assign near = ($signed({1'b0, depth_r}) - 10'sd4) <= $signed({2'b00, h_depth});
  always_comb begin
    p_status = ST_HIT;
    if (h_code == 2'd3) p_status = ST_INVALID;
    else if (deep && h_code == 2'd0) p_status = ST_EXACT;
    else if (deep && h_code == 2'd1 && s33 >= b33) p_status = ST_LOWER;
    else if (deep && h_code == 2'd2 && s33 <= a33) p_status = ST_UPPER;
    else if (near && h_code == 2'd2 && s33 < b33) p_status = ST_AVOIDNUL;
    else if (near && ((h_code == 2'd0 && s33 > a33) || (h_code == 2'd1 && s33 >= b33)))
      p_status = ST_GOOD;
  end

  // record write word
  logic [31:0] w_move, w_data;
  logic [1:0]  w_code;
  logic        w_mate;
  assign w_code = (bound_r == BND_REFRESH) ? 2'd3 : bound_r[1:0];
  assign w_move = (hit_r && move_r == 32'd0) ? h_move : move_r;
  assign w_mate = mate_r | (hit_r & h_flags[2]);
  assign w_data = {age_r, sing_r, w_mate, w_code, depth_r, adj_out};

  logic [31:0] x_data;
  assign x_data = {h_flags | 8'h03, 8'hff, h_data[15:0]};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tgt_r;
    ram_wdata = {keyhi_r ^ w_move ^ eval_r ^ w_data, w_data, eval_r, w_move};
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r[ADDR_W-1:0];
      ram_wdata = '0;
    end else if (state_r == S_WRITE) begin
      ram_we = 1'b1;
      if (!cmd_r) begin
        ram_wdata = {hit_ent_r[127:96] ^ h_data ^ x_data, x_data, h_eval, h_move};
      end
    end
  end

  // output register is free this cycle
  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    rd_cnt_nxt = rd_cnt_r;
    ev_cnt_nxt = ev_cnt_r;
    case (state_r)
      S_CLEAR: if (clr_r == (ADDR_W+1)'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        rd_cnt_nxt = '0;
        ev_cnt_nxt = '0;
        if (in_tvalid) state_nxt = S_READ;
      end
      S_READ: begin
        rd_cnt_nxt = rd_cnt_r + 1'b1;
        state_nxt  = S_EVAL;
      end
      S_EVAL: begin
        ev_cnt_nxt = ev_cnt_r + 1'b1;
        if (done_r || ev_cnt_r == (PRB_W+1)'(PROBES)) begin
          state_nxt = S_DONE;
        end else if ((!cmd_r && e_match) || rec_stop
                     || ev_cnt_r == (PRB_W+1)'(PROBES - 1)) begin
          state_nxt = S_DONE;
        end else begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
      end
      S_DONE: state_nxt = (cmd_r ? (found_r && !done_r) : (hit_r && excl_r && p_status == ST_HIT))
                          ? S_WRITE : S_WAIT;
      S_WRITE: state_nxt = S_WAIT;
      S_WAIT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      rd_cnt_r    <= '0;
      ev_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      ev_cnt_r <= ev_cnt_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      // a new result replaces a taken one in the same cycle
      if (state_r == S_WAIT && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      cmd_r   <= in_tuser;
      side_r  <= in_tdata[0];
      key_r   <= in_tdata[10:1] & index_mask_r;
      keyhi_r <= in_tdata[64:33];
      depth_r <= in_tdata[72:65];
      ply_r   <= in_tdata[80:73];
      bound_r <= (in_tdata[83:81] > BND_REFRESH) ? BND_INVALID : in_tdata[83:81];
      mate_r  <= in_tdata[84];
      sing_r  <= in_tdata[85];
      score_r <= in_tdata[101:86];
      eval_r  <= in_tdata[133:102];
      move_r  <= in_tdata[165:134];
      excl_r  <= in_tdata[166];
      found_r <= 1'b0;
      hit_r   <= 1'b0;
      done_r  <= 1'b0;
      best_r  <= 10'h3ff;
    end
    if (state_r == S_EVAL && !done_r && ev_cnt_r < (PRB_W+1)'(PROBES)) begin
      if (cmd_r) begin
        if (e_empty || e_match) begin
          hit_ent_r <= ram_rdata;
          hit_r     <= 1'b1;
          found_r   <= 1'b1;
          tgt_r     <= slot_addr(side_r, key_r, ev_cnt_r);
          done_r    <= (bound_r == BND_REFRESH && e_move == move_r)
                    || (e_depth > depth_r && bound_r != BND_INVALID && e_code != 2'd3);
        end else if (e_sc < best_r) begin
          best_r  <= e_sc;
          tgt_r   <= slot_addr(side_r, key_r, ev_cnt_r);
          found_r <= 1'b1;
        end
      end else if (e_match) begin
        hit_ent_r <= ram_rdata;
        hit_r     <= 1'b1;
        tgt_r     <= slot_addr(side_r, key_r, ev_cnt_r);
      end
    end
    // load only once the previous result has left
    if (state_r == S_WAIT && out_free) begin
      if (cmd_r) begin
        o_status_r <= ST_RECORDED;
        o_score_r  <= '0;
        o_eval_r   <= '0;
        o_move_r   <= '0;
        o_mate_r   <= 1'b0;
        o_sing_r   <= 1'b0;
        o_depth_r  <= '0;
      end else if (hit_r) begin
        o_status_r <= p_status;
        o_score_r  <= adj_out;
        o_eval_r   <= h_eval;
        o_move_r   <= h_move;
        o_mate_r   <= mate_r | h_flags[2];
        o_sing_r   <= h_flags[3];
        o_depth_r  <= h_depth;
      end else begin
        o_status_r <= ST_UNKNOWN;
        o_score_r  <= '0;
        o_eval_r   <= '0;
        o_move_r   <= '0;
        o_mate_r   <= mate_r;
        o_sing_r   <= 1'b0;
        o_depth_r  <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, o_depth_r, o_sing_r, o_mate_r, o_move_r, o_eval_r,
                       o_score_r, o_status_r};
endmodule

// File: rtl/ttb_checker.sv
module ttb_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [ttb_pkg::OUT_W-1:0] out_tdata
);
  import ttb_pkg::*;
`include "transposition_table_bucket_top_assert.svh"

  `TTB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `TTB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `TTB_ASSERT_IMPL(a_status_range, clk, rst_n, out_tvalid, out_tdata[3:0] <= ST_RECORDED)
  `TTB_ASSERT_IMPL(a_rec_zero, clk, rst_n, out_tvalid && out_tdata[3:0] == ST_RECORDED,
    out_tdata[95:4] == '0)
endmodule

bind transposition_table_bucket_top ttb_checker u_ttb_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// File: tb/sv/transposition_table_bucket_top_test.sv
module transposition_table_bucket_top_test;
  import ttb_pkg::*;

  localparam bit CMD_PROBE  = 1'b0;
  localparam bit CMD_RECORD = 1'b1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 12;

  // One command; cmd travels on in_tuser, the rest on in_tdata.
  typedef struct packed {
    logic        exclusive;
    logic [31:0] move;
    logic [31:0] eval_or_beta;
    logic [15:0] score_or_alpha;
    logic [1:0]  marks;
    logic [2:0]  bound;
    logic [7:0]  ply;
    logic [7:0]  depth;
    logic [63:0] pos_key;
    logic        side;
    logic        cmd;
  } tt_cmd_t;

  // One verdict as it travels on out_tdata (minus the pad).
  typedef struct packed {
    logic [7:0]  stored_depth;
    logic        singular;
    logic        mate_flag;
    logic [31:0] move;
    logic [31:0] eval_w;
    logic [15:0] score;
    logic [3:0]  status;
  } tt_verdict_t;

  // Directed row: typed status is used only where it is obvious.
  typedef struct {
    tt_cmd_t    c;
    bit         typed;
    logic [3:0] st;
  } dir_row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [14:0] cfg_data;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic in_tuser;
  logic [IN_W-1:0] in_tdata;
  logic [OUT_W-1:0] out_tdata;

  transposition_table_bucket_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Shadow table: move, eval, data word, check word per slot.
  logic [31:0] sh_move [DEPTH];
  logic [31:0] sh_eval [DEPTH];
  logic [31:0] sh_data [DEPTH];
  logic [31:0] sh_chk  [DEPTH];
  logic [9:0]  m_index_mask;
  logic [3:0]  m_age;
  logic [14:0] m_win_thr;
  logic [7:0]  m_win_step;

  tt_verdict_t verdict_q[$];
  int mismatches = 0;
  int verdicts_seen = 0;
  int transfers_in, records_sent, probes_sent;
  int send_idle_pct, rcv_idle_pct;
  bit hold_go;
  bit hold_done = 0;
  int hold_cnt = 0;
  int cycles = 0;
  logic [63:0] key_pool[16];
  logic [31:0] move_pool[8];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic [10:0] slot_of(logic side, logic [9:0] key, int i);
    return {side, key ^ 10'(i)};
  endfunction

  function automatic void table_record(tt_cmd_t c);
    logic [9:0]  key = c.pos_key[9:0] & m_index_mask;
    logic [31:0] keyhi = c.pos_key[63:32];
    logic [2:0]  bnd = (c.bound > BND_REFRESH) ? BND_INVALID : c.bound;
    logic        mate = c.marks[0];
    logic [31:0] mv = c.move;
    int          score = $signed(c.score_or_alpha);
    int          adj = int'(m_win_step) * (int'(c.ply) + 1);
    int          best = 32'h7fffffff;
    logic [10:0] target = '0;
    logic [10:0] a;
    logic [7:0]  sf, sd;
    logic [1:0]  code;
    logic [31:0] dw;
    bit          found = 0;
    int          sc;
    for (int i = 0; i < PROBES; i++) begin
      a = slot_of(c.side, key, i);
      sf = sh_data[a][31:24];
      sd = sh_data[a][23:16];
      if (sh_chk[a] == 0 || (sh_chk[a] ^ sh_move[a] ^ sh_eval[a] ^ sh_data[a]) == keyhi) begin
        if (bnd == BND_REFRESH && sh_move[a] == mv) return;
        if (sd > c.depth && bnd != BND_INVALID && sf[1:0] != 2'd3) return;
        if (mv == 0) mv = sh_move[a];
        if (sf[2]) mate = 1'b1;
        target = a;
        found = 1;
        break;
      end else begin
        sc = int'(sf & 8'hf0) + int'(sd) + ((sf[1:0] != 0) ? 0 : 64);
        if (sc < best) begin
          best = sc;
          target = a;
          found = 1;
        end
      end
    end
    if (!found) return;
    if (score > int'(m_win_thr)) score = sat16(score + adj);
    else if (score < -int'(m_win_thr)) score = sat16(score - adj);
    code = (bnd == BND_REFRESH) ? 2'd3 : bnd[1:0];
    dw = {m_age, c.marks[1], mate, code, c.depth, score[15:0]};
    sh_move[target] = mv;
    sh_eval[target] = c.eval_or_beta;
    sh_data[target] = dw;
    sh_chk[target]  = keyhi ^ mv ^ c.eval_or_beta ^ dw;
  endfunction

  function automatic tt_verdict_t table_probe(tt_cmd_t c);
    tt_verdict_t v = '0;
    logic [9:0]  key = c.pos_key[9:0] & m_index_mask;
    logic [31:0] keyhi = c.pos_key[63:32];
    int          depth = c.depth;
    int          adj = int'(m_win_step) * (int'(c.ply) + 1);
    longint      alpha = longint'($signed(c.score_or_alpha));
    longint      beta = longint'($signed(c.eval_or_beta));
    logic [10:0] a;
    logic [7:0]  sf;
    logic [31:0] nd;
    int          hd, score;
    v.mate_flag = c.marks[0];
    v.status = ST_UNKNOWN;
    for (int i = 0; i < PROBES; i++) begin
      a = slot_of(c.side, key, i);
      if ((sh_chk[a] ^ sh_move[a] ^ sh_eval[a] ^ sh_data[a]) != keyhi) continue;
      sf = sh_data[a][31:24];
      hd = sh_data[a][23:16];
      score = $signed(sh_data[a][15:0]);
      if (score > int'(m_win_thr)) score = sat16(score - adj);
      else if (score < -int'(m_win_thr)) score = sat16(score + adj);
      v.score = score[15:0];
      v.eval_w = sh_eval[a];
      v.move = sh_move[a];
      v.mate_flag = c.marks[0] | sf[2];
      v.singular = sf[3];
      v.stored_depth = hd[7:0];
      if (sf[1:0] == 2'd3) v.status = ST_INVALID;
      else if (hd >= depth && sf[1:0] == 2'd0) v.status = ST_EXACT;
      else if (hd >= depth && sf[1:0] == 2'd1 && score >= beta) v.status = ST_LOWER;
      else if (hd >= depth && sf[1:0] == 2'd2 && score <= alpha) v.status = ST_UPPER;
      else if (depth - 4 <= hd && sf[1:0] == 2'd2 && score < beta) v.status = ST_AVOIDNUL;
      else if (depth - 4 <= hd && ((sf[1:0] == 2'd0 && score > alpha) ||
               (sf[1:0] == 2'd1 && score >= beta))) v.status = ST_GOOD;
      else begin
        // exclusive hit: mark invalid, depth 255, keep checksum consistent
        if (c.exclusive) begin
          nd = {sf | 8'h03, 8'hff, sh_data[a][15:0]};
          sh_chk[a] = sh_chk[a] ^ sh_data[a] ^ nd;
          sh_data[a] = nd;
        end
        v.status = ST_HIT;
      end
      return v;
    end
    return v;
  endfunction

  function automatic tt_verdict_t table_step(tt_cmd_t c);
    tt_verdict_t v = '0;
    if (c.cmd == CMD_RECORD) begin
      table_record(c);
      v.status = ST_RECORDED;
    end else begin
      v = table_probe(c);
    end
    return v;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INDEX_MASK: m_index_mask = val[9:0];
      CFG_AGE:        m_age = val[3:0];
      CFG_WIN_THR:    m_win_thr = val;
      CFG_WIN_STEP:   m_win_step = val[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [9:0] msk, logic [3:0] ag, logic [14:0] thr, logic [7:0] stp);
    write_reg(CFG_INDEX_MASK, 15'(msk));
    write_reg(CFG_AGE, 15'(ag));
    write_reg(CFG_WIN_THR, thr);
    write_reg(CFG_WIN_STEP, 15'(stp));
  endtask

  // Wait for every outstanding verdict, then let the pipeline settle.
  task automatic drain();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Offer one command; valid stays high into the next call unless it idles.
  task automatic send_cmd(tt_cmd_t c, bit typed, logic [3:0] st);
    tt_verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c.cmd;
    in_tdata <= {1'b0, c[$bits(tt_cmd_t)-1:1]};
    do @(posedge clk); while (!in_tready);
    v = table_step(c);
    if (typed) v.status = st;
    verdict_q.push_back(v);
    transfers_in++;
    if (c.cmd == CMD_RECORD) records_sent++;
    else probes_sent++;
  endtask

  function automatic tt_cmd_t rand_cmd();
    tt_cmd_t c;
    int r = $urandom_range(99);
    c.cmd = 1'($urandom_range(1));
    c.side = 1'($urandom_range(1));
    if (r < 8) c.pos_key = {$urandom, $urandom};
    else if (r < 40) c.pos_key = {key_pool[$urandom_range(15)][63:32], 22'd0, 10'($urandom)};
    else c.pos_key = key_pool[$urandom_range(15)];
    c.depth = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(24));
    c.ply = 8'($urandom);
    r = $urandom_range(99);
    c.bound = (r < 8) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    c.marks = 2'($urandom_range(3));
    r = $urandom_range(99);
    if (r < 20) c.score_or_alpha = 16'($urandom_range(65534) - 32767);
    else if (r < 40) c.score_or_alpha = 16'(32767 - $urandom_range(400));
    else if (r < 55) c.score_or_alpha = 16'(-32767 + $urandom_range(400));
    else c.score_or_alpha = 16'($urandom_range(600) - 300);
    c.eval_or_beta = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(600) - 300);
    r = $urandom_range(99);
    c.move = (r < 15) ? 32'd0 : (r < 65) ? move_pool[$urandom_range(7)] : $urandom;
    c.exclusive = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic tt_cmd_t mk(bit cmd, bit side, logic [63:0] key, int depth, int ply,
                                 int bnd, int marks, int score, int evalv, logic [31:0] mv,
                                 bit excl);
    tt_cmd_t c;
    c.cmd = cmd; c.side = side; c.pos_key = key; c.depth = 8'(depth); c.ply = 8'(ply);
    c.bound = 3'(bnd); c.marks = 2'(marks); c.score_or_alpha = 16'(score);
    c.eval_or_beta = 32'(evalv);
    c.move = mv; c.exclusive = excl;
    return c;
  endfunction

  // Receiver: random stalls plus one long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      out_tready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= 400) hold_done = 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Result checker: each transfer on the output side against the oldest verdict.
  always @(posedge clk) begin
    tt_verdict_t act, exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      act = out_tdata[$bits(tt_verdict_t)-1:0];
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected verdict %h", act);
      end else begin
        exp_v = verdict_q.pop_front();
        if (act !== exp_v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict %0d: exp st=%0d sc=%h ev=%h mv=%h mt=%b sg=%b d=%0d | act st=%0d sc=%h ev=%h mv=%h mt=%b sg=%b d=%0d",
                     verdicts_seen, exp_v.status, exp_v.score, exp_v.eval_w, exp_v.move,
                     exp_v.mate_flag, exp_v.singular, exp_v.stored_depth,
                     act.status, act.score, act.eval_w, act.move,
                     act.mate_flag, act.singular, act.stored_depth);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycles, verdict_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    logic [63:0] kb;
    // all inputs but out_tready known from time zero
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_tvalid = 1'b0; in_tuser = 1'b0; in_tdata = '0;
    transfers_in = 0;
    records_sent = 0; probes_sent = 0;
    hold_go = 0;
    send_idle_pct = 0; rcv_idle_pct = 0;
    for (int i = 0; i < DEPTH; i++) begin
      sh_move[i] = '0; sh_eval[i] = '0; sh_data[i] = '0; sh_chk[i] = '0;
    end
    m_index_mask = 10'd255; m_age = 4'd0; m_win_thr = 15'd3000; m_win_step = 8'd1;
    for (int i = 0; i < 16; i++)
      key_pool[i] = {$urandom_range(5) == 0 ? 32'hffff_ffff : $urandom, $urandom};
    for (int i = 0; i < 8; i++) move_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass at reset-like settings; config goes in during the clearing pass.
    configure(10'd255, 4'd5, 15'd3000, 8'd1);
    kb = 64'h1234_5678_0000_0042;
    rows.push_back('{mk(CMD_PROBE, 0, kb, 5, 0, 0, 1, 0, 0, 0, 0), 1, ST_UNKNOWN});
    rows.push_back('{mk(CMD_RECORD, 0, kb, 10, 3, BND_EXACT, 0, 100, 32'h8000_0000,
                        32'hffff_ffff, 0), 1, ST_RECORDED});
    rows.push_back('{mk(CMD_PROBE, 0, kb, 5, 3, 0, 0, 50, 200, 0, 0), 0, 0});
    // hit-refresh with the same move leaves the slot alone
    rows.push_back('{mk(CMD_RECORD, 0, kb, 30, 0, BND_REFRESH, 0, 7, 7, 32'hffff_ffff, 0),
                     1, ST_RECORDED});
    // too shallow for a cutoff: plain hit, exclusive invalidates
    rows.push_back('{mk(CMD_PROBE, 0, kb, 20, 0, 0, 0, 500, 600, 0, 1), 0, 0});
    rows.push_back('{mk(CMD_PROBE, 0, kb, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_INVALID});
    // mate scores at the extremes, singular and mate marks
    rows.push_back('{mk(CMD_RECORD, 0, 64'h0bad_f00d_0000_0111, 8, 255, BND_LOWER, 3,
                        32767, 32'h7fff_ffff, 0, 0), 1, ST_RECORDED});
    rows.push_back('{mk(CMD_PROBE, 0, 64'h0bad_f00d_0000_0111, 8, 255, 0, 0,
                        0, -5, 0, 0), 0, 0});
    rows.push_back('{mk(CMD_RECORD, 0, 64'h0bad_f00d_0000_0111, 8, 0, BND_UPPER, 0,
                        -32767, 0, 32'h0000_0001, 0), 1, ST_RECORDED});
    rows.push_back('{mk(CMD_PROBE, 0, 64'h0bad_f00d_0000_0111, 6, 0, 0, 0,
                        32767, 0, 0, 0), 0, 0});
    // bound codes above hit-refresh fold to invalid
    rows.push_back('{mk(CMD_RECORD, 1, 64'h5555_aaaa_0000_0333, 4, 0, 7, 0, 1, 1, 9, 0),
                     1, ST_RECORDED});
    rows.push_back('{mk(CMD_PROBE, 1, 64'h5555_aaaa_0000_0333, 4, 0, 0, 0, 0, 0, 0, 0),
                     1, ST_INVALID});
    // five keys into one bucket: the fifth evicts the cheapest slot
    for (int i = 0; i < 5; i++)
      rows.push_back('{mk(CMD_RECORD, 1, {32'(i + 100), 32'h0000_0020}, 3 + i, 0,
                          (i == 2) ? BND_EXACT : BND_LOWER, 0, i * 10, i, 32'(i + 1), 0),
                       1, ST_RECORDED});
    rows.push_back('{mk(CMD_PROBE, 1, {32'd100, 32'h0000_0020}, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0});
    rows.push_back('{mk(CMD_PROBE, 1, {32'd104, 32'h0000_0020}, 0, 0, 0, 0, -100, 100, 0, 0),
                     0, 0});
    rows.push_back('{mk(CMD_RECORD, 1, 64'hffff_ffff_ffff_ffff, 255, 0, BND_UPPER, 0,
                        0, 0, 0, 0), 1, ST_RECORDED});
    rows.push_back('{mk(CMD_PROBE, 1, 64'hffff_ffff_ffff_ffff, 255, 0, 0, 0,
                        32'hffff_8001, 32'h7fff_ffff, 0, 1), 0, 0});
    foreach (rows[i]) send_cmd(rows[i].c, rows[i].typed, rows[i].st);
    in_tvalid <= 1'b0;
    drain();

    // Smallest mask, strongest mate shift; sender mostly busy, receiver mostly stalled.
    configure(10'd3, 4'd0, 15'd0, 8'd255);
    send_idle_pct = 12; rcv_idle_pct = 86;
    for (int n = 0; n < 500; n++) send_cmd(rand_cmd(), 0, 0);
    in_tvalid <= 1'b0;
    drain();

    // Widest mask, top age, no mate shift; roles of idling reversed.
    configure(10'd1023, 4'd15, 15'd32767, 8'd0);
    send_idle_pct = 86; rcv_idle_pct = 12;
    for (int n = 0; n < 500; n++) send_cmd(rand_cmd(), 0, 0);
    in_tvalid <= 1'b0;
    drain();

    // Mid settings, full rate, with a long receiver hold-off and one sender pause.
    configure(10'd63, 4'd9, 15'd2000, 8'd3);
    send_idle_pct = 0; rcv_idle_pct = 0;
    for (int n = 0; n < 530; n++) begin
      if (n == 100) hold_go = 1;
      if (n == 300) begin
        in_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
      end
      send_cmd(rand_cmd(), 0, 0);
    end
    in_tvalid <= 1'b0;
    drain();

    $display("covered %0d commands (%0d records, %0d probes) over four table settings",
             transfers_in, records_sent, probes_sent);
    $display("%0d verdicts checked, %0d mismatches", verdicts_seen, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
